/* rtl/line_pixel_rasterizer_unit_assert.svh */
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_unit_assert.svh
// Assertion macros for the line rasterizer. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_RASTERIZER_UNIT_ASSERT_SVH
`define LINE_PIXEL_RASTERIZER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared widths, defaults and register indexes of the line rasterizer.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int COORD_W       = 6;
  localparam int SIZE_W        = 7;
  localparam int TILE_SIZE_DEF = 64;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } lpr_reg_t;

endpackage

/* rtl/line_pixel_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_unit
// Rasterizes one line per request and streams out its pixels along the major
// axis, with the final pixel marked by out_tlast.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | slave     | tdata: start_x, start_y, end_x, end_y
// out_    | master    | tdata: pixel_x, pixel_y; tlast: final pixel
// cfg_    | slave     | index 0 image_width, index 1 image_height
//
// A line is captured in S_IDLE and set up in S_SETUP; S_RUN then emits one pixel
// per cycle while out_tready does not stall it, up to 64 pixels per line.
// A rejected line returns from S_SETUP to S_IDLE and gives no pixel.
// Each pixel costs one pass through the shared remainder add and correct unit.
// A stall on out_tready holds the sequencer; in_tready is high only when idle.
// rst_n is synchronous and restores both size registers to TILE_SIZE.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_unit
  import lpr_pkg::*;
#(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // start_x [5:0], start_y [11:6], end_x [17:12], end_y [23:18]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pixel_x [5:0], pixel_y [11:6], zero [15:12]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  lpr_reg_t              cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data
);

  localparam logic [SIZE_W-1:0] TILE_LIM = SIZE_W'(TILE_SIZE);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_RUN
  } state_t;

  state_t               state_r, state_nxt;
  logic [SIZE_W-1:0]    img_w_r, img_w_nxt;
  logic [SIZE_W-1:0]    img_h_r, img_h_nxt;
  logic [COORD_W-1:0]   x0_r, x0_nxt, y0_r, y0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  logic                 steep_r, steep_nxt;
  logic                 desc_r, desc_nxt;
  logic                 neg_r, neg_nxt;
  logic [COORD_W-1:0]   ad_r, ad_nxt;
  logic [COORD_W-1:0]   adm_r, adm_nxt;
  logic [COORD_W-1:0]   min0_r, min0_nxt;
  logic [COORD_W-1:0]   i_r, i_nxt;
  logic [COORD_W-1:0]   hi_r, hi_nxt;
  logic [COORD_W-1:0]   q_r, q_nxt;
  logic [COORD_W-1:0]   rem_r, rem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [COORD_W-1:0]   out_px_r, out_px_nxt, out_py_r, out_py_nxt;

  // Setup arithmetic
  logic [SIZE_W-1:0]    dx, dy;
  logic [COORD_W-1:0]   adx, ady;
  logic                 steep_c, coord_ok, size_ok;
  logic [COORD_W-1:0]   maj0, maj1;

  // Shared step unit
  logic [SIZE_W-1:0]    step_sum, step_fix;
  logic                 step_wrap;
  logic [COORD_W-1:0]   minor;
  logic                 load;

  always_comb begin
    dx       = {1'b0, x1_r} - {1'b0, x0_r};
    dy       = {1'b0, y1_r} - {1'b0, y0_r};
    adx      = dx[SIZE_W-1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady      = dy[SIZE_W-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    steep_c  = ady > adx;
    maj0     = steep_c ? y0_r : x0_r;
    maj1     = steep_c ? y1_r : x1_r;
    size_ok  = ({1'b0, x1_r} < img_w_r) && ({1'b0, y1_r} < img_h_r);
    coord_ok = ({1'b0, x0_r} < TILE_LIM) && ({1'b0, y0_r} < TILE_LIM) &&
               ({1'b0, x1_r} < TILE_LIM) && ({1'b0, y1_r} < TILE_LIM);
  end

  // One add and one correcting add track quotient and remainder of t*|dmin|/|dmaj|
  // as t moves by one per pixel, upward or downward.
  always_comb begin
    step_sum  = desc_r ? ({1'b0, rem_r} - {1'b0, adm_r}) : ({1'b0, rem_r} + {1'b0, adm_r});
    step_wrap = desc_r ? step_sum[SIZE_W-1] : (step_sum >= {1'b0, ad_r});
    step_fix  = desc_r ? (step_sum + {1'b0, ad_r}) : (step_sum - {1'b0, ad_r});
    // Floor of a negative quotient rounds one further down when a remainder is left.
    minor     = neg_r ? (min0_r - q_r - COORD_W'(rem_r != '0)) : (min0_r + q_r);
    load      = (state_r == S_RUN) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt     = state_r;
    img_w_nxt     = img_w_r;
    img_h_nxt     = img_h_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    steep_nxt     = steep_r;
    desc_nxt      = desc_r;
    neg_nxt       = neg_r;
    ad_nxt        = ad_r;
    adm_nxt       = adm_r;
    min0_nxt      = min0_r;
    i_nxt         = i_r;
    hi_nxt        = hi_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_px_nxt    = out_px_r;
    out_py_nxt    = out_py_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  img_w_nxt = cfg_data;
        REG_IMAGE_HEIGHT: img_h_nxt = cfg_data;
        default:          img_w_nxt = img_w_r;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x0_nxt    = in_tdata[5:0];
          y0_nxt    = in_tdata[11:6];
          x1_nxt    = in_tdata[17:12];
          y1_nxt    = in_tdata[23:18];
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        steep_nxt = steep_c;
        desc_nxt  = maj1 < maj0;
        neg_nxt   = steep_c ? (x1_r < x0_r) : (y1_r < y0_r);
        ad_nxt    = steep_c ? ady : adx;
        adm_nxt   = steep_c ? adx : ady;
        min0_nxt  = steep_c ? x0_r : y0_r;
        i_nxt     = (maj1 < maj0) ? maj1 : maj0;
        hi_nxt    = (maj1 < maj0) ? maj0 : maj1;
        // Walking down the major axis starts at t = |dmaj|, where the quotient is |dmin|.
        q_nxt     = (maj1 < maj0) ? (steep_c ? adx : ady) : '0;
        rem_nxt   = '0;
        state_nxt = (size_ok && coord_ok) ? S_RUN : S_IDLE;
      end
      S_RUN: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (i_r == hi_r);
          out_px_nxt    = steep_r ? minor : i_r;
          out_py_nxt    = steep_r ? i_r : minor;
          i_nxt         = i_r + COORD_W'(1);
          rem_nxt       = step_wrap ? step_fix[COORD_W-1:0] : step_sum[COORD_W-1:0];
          q_nxt         = step_wrap ? (desc_r ? q_r - COORD_W'(1) : q_r + COORD_W'(1)) : q_r;
          if (i_r == hi_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      img_w_r     <= TILE_LIM;
      img_h_r     <= TILE_LIM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      img_w_r     <= img_w_nxt;
      img_h_r     <= img_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    steep_r    <= steep_nxt;
    desc_r     <= desc_nxt;
    neg_r      <= neg_nxt;
    ad_r       <= ad_nxt;
    adm_r      <= adm_nxt;
    min0_r     <= min0_nxt;
    i_r        <= i_nxt;
    hi_r       <= hi_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    out_last_r <= out_last_nxt;
    out_px_r   <= out_px_nxt;
    out_py_r   <= out_py_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - 2 * COORD_W){1'b0}}, out_py_r, out_px_r};

`include "line_pixel_rasterizer_unit_assert.svh"

  `LPR_ASSERT_NEXT(a_busy_after_request, in_tvalid && in_tready, !in_tready, "accepted a request while busy")
  `LPR_ASSERT_NEXT(a_idle_after_last, load && (i_r == hi_r), state_r == S_IDLE, "sequencer ran past the final pixel")
  `LPR_ASSERT_NOW(a_step_in_range, state_r == S_RUN, i_r <= hi_r, "major coordinate beyond line end")

endmodule
